/* rtl/fls_pkg.sv */
// fading LED scanner: shared constants, register codes and inter-module structs
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package fls_pkg;

  localparam int STRIP_LENGTH = 41;
  localparam int MID_PIXEL    = STRIP_LENGTH / 2;
  localparam int PIX_W        = $clog2(STRIP_LENGTH);
  localparam int INDEX_W      = 6;
  localparam int CHAN_W       = 8;
  localparam int COLOR_W      = 3 * CHAN_W;
  localparam int PERIOD_W     = 16;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_COLOR   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_PERIOD  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_PERIOD = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP   = CFG_IDX_W'(4);

  localparam logic [COLOR_W-1:0]  HEAD_COLOR_RESET   = COLOR_W'(24'hFF0000);
  localparam logic [PERIOD_W-1:0] MOVE_PERIOD_RESET  = PERIOD_W'(100);
  localparam logic [PERIOD_W-1:0] DECAY_PERIOD_RESET = PERIOD_W'(20);
  localparam logic [CHAN_W-1:0]   DECAY_STEP_RESET   = CHAN_W'(5);

  // controls from the sequencer into the head tracker
  typedef struct packed {
    logic step;
    logic restart;
    logic new_mode;
  } head_ctrl_t;

  // head positions and frame trigger back to the sequencer
  typedef struct packed {
    logic [PIX_W-1:0] head_left;
    logic [PIX_W-1:0] head_right;
    logic             frame_go;
  } head_stat_t;

endpackage

`default_nettype wire

/* rtl/fls_fade_unit.sv */
// fading LED scanner: shared per-pixel unit, saturating fade of three channels
// and head painting; depends on fls_pkg
`timescale 1ns / 1ps
`default_nettype none

module fls_fade_unit
  import fls_pkg::*;
(
  input  wire logic [COLOR_W-1:0] px_in,
  input  wire logic [CHAN_W-1:0]  decay_step,
  input  wire logic               paint,
  input  wire logic [COLOR_W-1:0] head_color,
  output logic      [COLOR_W-1:0] px_out
);

  logic [COLOR_W-1:0] faded;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (px_in[c*CHAN_W +: CHAN_W] > decay_step) begin
        faded[c*CHAN_W +: CHAN_W] = px_in[c*CHAN_W +: CHAN_W] - decay_step;
      end else begin
        faded[c*CHAN_W +: CHAN_W] = '0;
      end
    end
  end

  assign px_out = paint ? head_color : faded;

endmodule

`default_nettype wire

/* rtl/fls_heads.sv */
// fading LED scanner: tick counters and head movement for sweep and center modes
// depends on fls_pkg
`timescale 1ns / 1ps
`default_nettype none

module fls_heads
  import fls_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire head_ctrl_t          ctrl,
  input  wire logic                scan_mode,
  input  wire logic [PERIOD_W-1:0] move_period,
  input  wire logic [PERIOD_W-1:0] decay_period,
  output head_stat_t               stat
);

  localparam logic [PIX_W-1:0] LAST_P = PIX_W'(STRIP_LENGTH - 1);
  localparam logic [PIX_W-1:0] MID_P  = PIX_W'(MID_PIXEL);
  localparam logic [PIX_W-1:0] ONE_P  = PIX_W'(1);
  localparam logic [PIX_W:0]   LAST_X = (PIX_W + 1)'(STRIP_LENGTH - 1);
  localparam logic [PIX_W:0]   TURN_X = (PIX_W + 1)'(STRIP_LENGTH - 2);
  localparam logic [PIX_W:0]   ONE_X  = (PIX_W + 1)'(1);
  localparam logic [PIX_W:0]   TWO_X  = (PIX_W + 1)'(2);

  logic [PIX_W-1:0]    head_left;
  logic [PIX_W-1:0]    head_right;
  logic                moving_up;
  logic [PERIOD_W-1:0] move_count;
  logic [PERIOD_W-1:0] decay_count;

  logic [PERIOD_W:0]   move_inc;
  logic [PERIOD_W:0]   decay_inc;
  logic                move_fire;
  logic                decay_fire;
  logic [PIX_W:0]      left_x;
  logic [PIX_W:0]      right_x;
  logic [PIX_W-1:0]    head_left_next;
  logic [PIX_W-1:0]    head_right_next;
  logic                moving_up_next;

  // one bit wider so a period of all ones still fires
  assign move_inc   = {1'b0, move_count} + (PERIOD_W + 1)'(1);
  assign decay_inc  = {1'b0, decay_count} + (PERIOD_W + 1)'(1);
  assign move_fire  = move_inc > {1'b0, move_period};
  assign decay_fire = decay_inc > {1'b0, decay_period};

  assign left_x  = {1'b0, head_left};
  assign right_x = {1'b0, head_right};

  always_comb begin
    head_left_next  = head_left;
    head_right_next = head_right;
    moving_up_next  = moving_up;
    if (!scan_mode) begin
      if (moving_up) begin
        if (left_x >= TURN_X) begin
          head_left_next = LAST_P;
          moving_up_next = 1'b0;
        end else begin
          head_left_next = head_left + ONE_P;
        end
      end else if (left_x <= ONE_X) begin
        head_left_next = '0;
        moving_up_next = 1'b1;
      end else begin
        head_left_next = head_left - ONE_P;
      end
    end else if (moving_up) begin
      // expanding: clamp at the strip ends and start closing
      if (head_left == '0 || right_x >= LAST_X) begin
        moving_up_next  = 1'b0;
        head_left_next  = (head_left == '0) ? '0 : head_left - ONE_P;
        head_right_next = (right_x >= LAST_X) ? LAST_P : head_right + ONE_P;
      end else begin
        head_left_next  = head_left - ONE_P;
        head_right_next = head_right + ONE_P;
      end
    end else if (left_x + TWO_X >= right_x) begin
      // heads meet or cross: back to the middle
      moving_up_next  = 1'b1;
      head_left_next  = MID_P;
      head_right_next = MID_P;
    end else begin
      head_left_next  = head_left + ONE_P;
      head_right_next = head_right - ONE_P;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_left   <= '0;
      head_right  <= MID_P;
      moving_up   <= 1'b1;
      move_count  <= '0;
      decay_count <= '0;
    end else if (ctrl.restart) begin
      head_left  <= ctrl.new_mode ? MID_P : '0;
      head_right <= MID_P;
      moving_up  <= 1'b1;
    end else if (ctrl.step) begin
      if (move_fire) begin
        move_count <= '0;
        head_left  <= head_left_next;
        head_right <= head_right_next;
        moving_up  <= moving_up_next;
      end else begin
        move_count <= move_inc[PERIOD_W-1:0];
      end
      decay_count <= decay_fire ? '0 : decay_inc[PERIOD_W-1:0];
    end
  end

  assign stat.head_left  = head_left;
  assign stat.head_right = head_right;
  assign stat.frame_go   = ctrl.step && decay_fire;

  a_left_in_strip: assert property (@(posedge clk) disable iff (rst)
    left_x <= LAST_X && right_x <= LAST_X)
    else $error("head outside strip");

  a_center_order: assert property (@(posedge clk) disable iff (rst)
    scan_mode |-> left_x <= right_x)
    else $error("center heads crossed");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    ctrl.restart |=> (moving_up && head_right == MID_P))
    else $error("mode write did not restart heads");

endmodule

`default_nettype wire

/* rtl/fading_led_scanner.sv */
// fading LED scanner top level: configuration registers, frame memory and
// the pixel sequencer; depends on fls_pkg, fls_heads and fls_fade_unit
//
// usage: one input transaction per millisecond tick (tick = 0 is accepted and
// does nothing). the move and decay counters count ticks; when the decay
// period is exceeded the whole frame is faded, the heads are painted and all
// STRIP_LENGTH pixels are sent, in order, one output transaction per pixel,
// frame_last marking the final one.
// timing: a frame walks the shared fade unit over the frame memory one pixel at
// a time, each pixel passing through a memory read state (S_READ) and then a
// write-back/output state (S_EMIT). in_stall stays high for the whole walk.
// stalls: out_stall holds the output register and the walk pauses on the
// current pixel; nothing is lost or repeated.
// configuration: cfg_ready is always high; write only while no frame is being
// sent. writing scan_mode restarts the heads.
// reset: synchronous; registers take their defaults, the frame reads black
// through per-pixel valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module fading_led_scanner
  import fls_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 tick,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [INDEX_W-1:0]   pixel_index,
  output logic      [CHAN_W-1:0]    red,
  output logic      [CHAN_W-1:0]    green,
  output logic      [CHAN_W-1:0]    blue,
  output logic                      frame_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data
);

  localparam logic [PIX_W-1:0] LAST_IDX = PIX_W'(STRIP_LENGTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} state_t;

  state_t              state;
  logic [PIX_W-1:0]    idx;
  logic                scan_mode;
  logic [COLOR_W-1:0]  head_color;
  logic [PERIOD_W-1:0] move_period;
  logic [PERIOD_W-1:0] decay_period;
  logic [CHAN_W-1:0]   decay_step;
  logic [STRIP_LENGTH-1:0] pix_valid;

  logic [COLOR_W-1:0]  frame_mem [STRIP_LENGTH];
  logic [COLOR_W-1:0]  rd_data;
  logic                rd_valid;

  head_ctrl_t          hctrl;
  head_stat_t          hstat;
  logic                in_take;
  logic                cfg_take;
  logic                emit_go;
  logic                paint;
  logic [COLOR_W-1:0]  px_in;
  logic [COLOR_W-1:0]  px_new;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;

  assign hctrl.step     = in_take && tick;
  assign hctrl.restart  = cfg_take && (cfg_index == REG_SCAN_MODE);
  assign hctrl.new_mode = cfg_data[0];

  fls_heads u_heads (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (hctrl),
    .scan_mode    (scan_mode),
    .move_period  (move_period),
    .decay_period (decay_period),
    .stat         (hstat)
  );

  assign paint = (idx == hstat.head_left) || (scan_mode && idx == hstat.head_right);
  assign px_in = rd_valid ? rd_data : '0;

  fls_fade_unit u_fade (
    .px_in      (px_in),
    .decay_step (decay_step),
    .paint      (paint),
    .head_color (head_color),
    .px_out     (px_new)
  );

  assign emit_go = (state == S_EMIT) && (!out_valid || !out_stall);

  // frame memory: registered read at the walk index, write-back on emit
  always_ff @(posedge clk) begin
    rd_data  <= frame_mem[idx];
    rd_valid <= pix_valid[idx];
    if (emit_go) begin
      frame_mem[idx] <= px_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      out_valid    <= 1'b0;
      pix_valid    <= '0;
      scan_mode    <= 1'b0;
      head_color   <= HEAD_COLOR_RESET;
      move_period  <= MOVE_PERIOD_RESET;
      decay_period <= DECAY_PERIOD_RESET;
      decay_step   <= DECAY_STEP_RESET;
    end else begin
      if (cfg_take) begin
        unique case (cfg_index)
          REG_SCAN_MODE:    scan_mode    <= cfg_data[0];
          REG_HEAD_COLOR:   head_color   <= cfg_data;
          REG_MOVE_PERIOD:  move_period  <= cfg_data[PERIOD_W-1:0];
          REG_DECAY_PERIOD: decay_period <= cfg_data[PERIOD_W-1:0];
          REG_DECAY_STEP:   decay_step   <= cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && !emit_go) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (hstat.frame_go) begin
            idx   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid      <= 1'b1;
            pixel_index    <= INDEX_W'(idx);
            red            <= px_new[3*CHAN_W-1:2*CHAN_W];
            green          <= px_new[2*CHAN_W-1:CHAN_W];
            blue           <= px_new[CHAN_W-1:0];
            frame_last     <= (idx == LAST_IDX);
            pix_valid[idx] <= 1'b1;
            if (idx == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + PIX_W'(1);
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (emit_go && idx == LAST_IDX) |=> state == S_IDLE)
    else $error("walk did not end after last pixel");

  a_mid_frame_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_last) |-> state != S_IDLE)
    else $error("idle with a frame half sent");

  a_stall_holds_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && out_stall) |=> (state == S_EMIT && $stable(idx)))
    else $error("walk advanced under output stall");

endmodule

`default_nettype wire

/* sim/fading_led_scanner_tb.sv */
// testbench for fading_led_scanner: random ticks and register settings with a
// scoreboard that predicts every emitted frame pixel by pixel
// depends on fls_pkg and the rtl of fading_led_scanner
`timescale 1ns / 1ps

module fading_led_scanner_tb
  import fls_pkg::*;
;

  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 30;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [CHAN_W-1:0]  r;
    logic [CHAN_W-1:0]  g;
    logic [CHAN_W-1:0]  b;
    logic               last;
  } pixel_t;

  class frame_scoreboard;
    bit                  scan_mode;
    logic [COLOR_W-1:0]  head_color;
    logic [PERIOD_W-1:0] move_period;
    logic [PERIOD_W-1:0] decay_period;
    logic [CHAN_W-1:0]   decay_step;
    logic [COLOR_W-1:0]  strip [STRIP_LENGTH];
    int                  head_l;
    int                  head_r;
    bit                  expanding;
    logic [PERIOD_W-1:0] move_cnt;
    logic [PERIOD_W-1:0] decay_cnt;
    pixel_t              due [$];
    int unsigned         errors;
    int unsigned         frames;
    int unsigned         pixels;

    function new();
      scan_mode    = 1'b0;
      head_color   = HEAD_COLOR_RESET;
      move_period  = MOVE_PERIOD_RESET;
      decay_period = DECAY_PERIOD_RESET;
      decay_step   = DECAY_STEP_RESET;
      foreach (strip[i]) strip[i] = '0;
      move_cnt  = '0;
      decay_cnt = '0;
      errors = 0;
      frames = 0;
      pixels = 0;
      restart_heads();
    endfunction

    function void restart_heads();
      expanding = 1'b1;
      head_r    = MID_PIXEL;
      head_l    = scan_mode ? MID_PIXEL : 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
      case (idx)
        REG_SCAN_MODE: begin
          scan_mode = data[0];
          restart_heads();
        end
        REG_HEAD_COLOR:   head_color   = data;
        REG_MOVE_PERIOD:  move_period  = data[PERIOD_W-1:0];
        REG_DECAY_PERIOD: decay_period = data[PERIOD_W-1:0];
        REG_DECAY_STEP:   decay_step   = data[CHAN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CHAN_W-1:0] fade(logic [CHAN_W-1:0] c);
      return (c > decay_step) ? c - decay_step : '0;
    endfunction

    function void step_heads();
      if (!scan_mode) begin
        if (expanding) begin
          head_l++;
          if (head_l >= STRIP_LENGTH - 1) begin
            head_l    = STRIP_LENGTH - 1;
            expanding = 1'b0;
          end
        end else begin
          head_l--;
          if (head_l <= 0) begin
            head_l    = 0;
            expanding = 1'b1;
          end
        end
      end else if (expanding) begin
        head_l--;
        head_r++;
        if (head_l < 0 || head_r >= STRIP_LENGTH) begin
          expanding = 1'b0;
          if (head_l < 0) head_l = 0;
          if (head_r > STRIP_LENGTH - 1) head_r = STRIP_LENGTH - 1;
        end
      end else begin
        head_l++;
        head_r--;
        if (head_l >= head_r) begin
          expanding = 1'b1;
          head_l    = MID_PIXEL;
          head_r    = MID_PIXEL;
        end
      end
    endfunction

    // one accepted input transaction; queues the frame it triggers, if any
    function void note_tick(bit t);
      logic [PERIOD_W:0] nxt;
      pixel_t            px;
      if (!t) return;
      nxt = {1'b0, move_cnt} + 1'b1;
      if (nxt > {1'b0, move_period}) begin
        move_cnt = '0;
        step_heads();
      end else begin
        move_cnt = nxt[PERIOD_W-1:0];
      end
      nxt = {1'b0, decay_cnt} + 1'b1;
      if (nxt <= {1'b0, decay_period}) begin
        decay_cnt = nxt[PERIOD_W-1:0];
        return;
      end
      decay_cnt = '0;
      foreach (strip[i])
        strip[i] = {fade(strip[i][23:16]), fade(strip[i][15:8]), fade(strip[i][7:0])};
      strip[head_l] = head_color;
      if (scan_mode) strip[head_r] = head_color;
      for (int i = 0; i < STRIP_LENGTH; i++) begin
        px.idx  = INDEX_W'(i);
        px.r    = strip[i][23:16];
        px.g    = strip[i][15:8];
        px.b    = strip[i][7:0];
        px.last = (i == STRIP_LENGTH - 1);
        due.push_back(px);
      end
      frames++;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (due.size() == 0) begin
        $error("pixel %0d emitted with no frame pending", got.idx);
        errors++;
        return;
      end
      want = due.pop_front();
      pixels++;
      if (got.idx !== want.idx) begin
        $error("pixel_index: expected %0d, got %0d", want.idx, got.idx);
        errors++;
      end
      if (got.r !== want.r) begin
        $error("red: expected %0d, got %0d", want.r, got.r);
        errors++;
      end
      if (got.g !== want.g) begin
        $error("green: expected %0d, got %0d", want.g, got.g);
        errors++;
      end
      if (got.b !== want.b) begin
        $error("blue: expected %0d, got %0d", want.b, got.b);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("frame_last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 tick = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [INDEX_W-1:0]   pixel_index;
  logic [CHAN_W-1:0]    red;
  logic [CHAN_W-1:0]    green;
  logic [CHAN_W-1:0]    blue;
  logic                 frame_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data = '0;

  frame_scoreboard board = new();
  int          idle_pct = 0;
  bit          hold_req = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int unsigned ticks_sent = 0;
  int unsigned settings = 0;

  fading_led_scanner dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .tick        (tick),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .frame_last  (frame_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_pixel({pixel_index, red, green, blue, frame_last});
  end

  // receiver: random stall bursts, or one long hold when asked
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      out_stall  = 1'b1;
      stall_left = HOLD_CYCLES - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_tick(input bit t);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) begin
        tick = 1'($urandom_range(0, 1));
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    tick     = t;
    do @(posedge clk); while (in_stall);
    board.note_tick(t);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input bit mode, input logic [COLOR_W-1:0] color,
                                input logic [PERIOD_W-1:0] mv, input logic [PERIOD_W-1:0] dc,
                                input logic [CHAN_W-1:0] dstep);
    write_cfg(REG_HEAD_COLOR, color);
    write_cfg(REG_MOVE_PERIOD, COLOR_W'(mv));
    write_cfg(REG_DECAY_PERIOD, COLOR_W'(dc));
    write_cfg(REG_DECAY_STEP, COLOR_W'(dstep));
    write_cfg(REG_SCAN_MODE, COLOR_W'(mode));
    settings++;
  endtask

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] pick_step();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return CHAN_W'($urandom_range(0, 255));
      default: return CHAN_W'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_tick($urandom_range(0, 9) != 0);
  endtask

  initial begin
    logic [PERIOD_W-1:0] mv;
    logic [PERIOD_W-1:0] dc;

    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: idle ticks at defaults, then fast periods and extreme colors
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_drained();
    apply_settings(1'b0, '1, '0, '0, '0);
    repeat (3) send_tick(1'b1);
    wait_drained();
    apply_settings(1'b0, '0, '0, '0, '1);
    send_tick(1'b1);
    wait_drained();
    apply_settings(1'b0, COLOR_W'(24'h123456), 16'd1, 16'd1, 8'd5);
    repeat (4) send_tick(1'b1);
    wait_drained();
    apply_settings(1'b1, COLOR_W'(24'hA5C35A), '0, '0, 8'd40);
    repeat (4) send_tick(1'b1);
    wait_drained();
    // indexes past the register list must be ignored
    for (int k = REG_DECAY_STEP + 1; k < 2 ** CFG_IDX_W; k++)
      write_cfg(CFG_IDX_W'(k), COLOR_W'($urandom));
    send_tick(1'b0);
    send_tick(1'b1);
    wait_drained();

    // largest periods: nothing fires within a short run of ticks
    apply_settings(1'b0, COLOR_W'(24'h00FF00), '1, '1, 8'd9);
    repeat (12) send_tick(1'b1);
    wait_drained();

    // long receiver hold while ticks keep coming, so the input backs up
    apply_settings(1'b1, pick_color(), '0, '0, pick_step());
    hold_req = 1'b1;
    repeat (6) send_tick(1'b1);
    wait_drained();

    // full sweep out and back, then center spread to the edges and back
    idle_pct = 30;
    apply_settings(1'b0, pick_color(), '0, 16'd3, pick_step());
    repeat (90) send_tick(1'b1);
    wait_drained();
    apply_settings(1'b1, pick_color(), '0, 16'd2, pick_step());
    repeat (50) send_tick(1'b1);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_pct = (p % 3 == 2) ? 0 : 15 * $urandom_range(1, 3);
      case ($urandom_range(0, 4))
        0:       mv = '0;
        1:       mv = 16'd1;
        2:       mv = PERIOD_W'($urandom);
        default: mv = PERIOD_W'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 3))
        0:       dc = '0;
        1:       dc = 16'd1;
        default: dc = PERIOD_W'($urandom_range(0, 5));
      endcase
      apply_settings(1'($urandom_range(0, 1)), pick_color(), mv, dc, pick_step());
      run_random(PHASE_ITEMS);
      // a mode write mid-run restarts the heads but keeps counters and frame
      if ($urandom_range(0, 1)) begin
        wait_drained();
        write_cfg(REG_SCAN_MODE, COLOR_W'($urandom_range(0, 1)));
        run_random(8);
      end
      wait_drained();
    end

    // closing stretch with no idling on either side
    idle_pct = 0;
    apply_settings(1'($urandom_range(0, 1)), pick_color(), '0, '0, pick_step());
    run_random(20);
    wait_drained();
    repeat (END_CYCLES) @(negedge clk);

    if (board.pending() != 0) begin
      $error("%0d pixels never emitted", board.pending());
      board.errors++;
    end
    $display("run covered %0d ticks over %0d register settings", ticks_sent, settings);
    $display("checked %0d frames, %0d pixels, %0d mismatches",
             board.frames, board.pixels, board.errors);
    if (board.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
